[src/dss_pkg.sv]
// Shared types, constants and helper functions for the drum step sequencer.
`default_nettype none
package dss_pkg;

	localparam int STEPS_DEF  = 16;
	localparam int VOICES_DEF = 6;
	localparam int SLOTS_DEF  = 8;

	localparam int ELAPSED_W = 16;
	localparam int NUM_W     = 23;
	localparam int DEN_W     = 16;
	localparam int QUO_W     = 10;
	localparam int CNT_W     = $clog2(QUO_W);

	localparam logic [7:0]  TEMPO_MIN   = 8'd40;
	localparam logic [7:0]  TEMPO_MAX   = 8'd240;
	localparam logic [5:0]  SWING_MAX   = 6'd50;
	localparam logic [8:0]  SWING_SCALE = 9'd200;
	localparam logic [13:0] STEP_MS_NUM = 14'd15000;

	localparam logic [1:0] CFG_TEMPO = 2'd0;
	localparam logic [1:0] CFG_SWING = 2'd1;
	localparam logic [1:0] CFG_SLOT  = 2'd2;

	localparam logic [7:0] TEMPO_RST = 8'd120;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_NEXT_VOICE,
		KIND_PLAY_STOP,
		KIND_TOGGLE_STEP
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_TRIG,
		S_ROW_RD,
		S_ROW_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] step_key;
	} in_word_t;

	typedef struct packed {
		logic        fired;
		logic        playhead_valid;
		logic [3:0]  step_index;
		logic [5:0]  triggers;
		logic        playing;
		logic [2:0]  selected_voice;
		logic [15:0] voice_row;
	} out_word_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	localparam logic [15:0] GROOVES [4][6] = '{
		'{16'h1111, 16'h1010, 16'h5555, 16'h0000, 16'h0000, 16'h0000},
		'{16'h1111, 16'h1010, 16'h4444, 16'h8080, 16'h0000, 16'h1010},
		'{16'h0441, 16'h9010, 16'hAAAA, 16'h0101, 16'h6000, 16'h1010},
		'{16'h4949, 16'h0000, 16'hAAAA, 16'h4444, 16'h1010, 16'h0100}
	};

	function automatic logic [15:0] groove_row(input logic [3:0] slot, input logic [3:0] voice);
		logic [15:0] r;
		r = '0;
		if (slot < 4'd4 && voice < 4'd6) begin
			r = GROOVES[slot[1:0]][voice[2:0]];
		end
		return r;
	endfunction

	function automatic logic [3:0] slot_mod(input logic [2:0] s, input int unsigned slots);
		logic [3:0] r;
		r = {1'b0, s};
		for (int i = 0; i < 8; i++) begin
			if (32'(r) >= slots) begin
				r = r - 4'(slots);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[src/drum_step_sequencer_swing.sv]
// One word is in work at a time. A tick while running waits on the interval divider
// (one quotient bit per cycle); a firing tick then reads each voice's row through the
// single read port of the pattern memory, and every event ends with a row read.
// Reset: playhead at step 0 and disarmed, sequencer running, kick selected;
// pattern rows read as the default grooves at once through per-row valid bits.
`default_nettype none
module drum_step_sequencer_swing #(
	parameter int STEPS  = dss_pkg::STEPS_DEF,
	parameter int VOICES = dss_pkg::VOICES_DEF,
	parameter int SLOTS  = dss_pkg::SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data,
	input  wire logic               evt_valid,
	output logic                    evt_ready,
	input  wire dss_pkg::in_word_t  evt,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output dss_pkg::out_word_t      res
);

	localparam int PW  = $clog2(STEPS);
	localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW  = dss_pkg::NUM_W;
	localparam int DW  = dss_pkg::DEN_W;
	localparam int EW  = dss_pkg::ELAPSED_W;

	dss_pkg::state_t   state_q, state_d;
	dss_pkg::kind_t    kind_q;
	dss_pkg::div_req_t div_req;
	dss_pkg::div_rsp_t div_rsp;
	dss_pkg::out_word_t res_q;

	logic [7:0]        tempo_q;
	logic [5:0]        swing_q;
	logic [2:0]        slot_q;
	logic [EW-1:0]     elapsed_q;
	logic [PW-1:0]     playhead_q;
	logic              armed_q;
	logic              running_q;
	logic              parity_q;
	logic [VW-1:0]     voice_q;
	logic              res_valid_q;
	logic [3:0]        key_q;
	logic              fired_q;
	logic [VOICES-1:0] trig_q;
	logic [STEPS-1:0]  row_q;
	logic [VW-1:0]     vcnt_q;
	logic              trig_pend_s1;
	logic [VW-1:0]     trig_v_s1;

	logic              accept;
	logic              div_start;
	logic              mem_rd_en;
	logic              mem_wr_en;
	logic              res_load;
	logic              fire;
	logic              key_ok;
	logic [7:0]        tempo_c;
	logic [5:0]        swing_c;
	logic [8:0]        factor;
	logic [SW-1:0]     slot_eff;
	logic [VW-1:0]     rd_voice;
	logic [STEPS-1:0]  rd_data;
	logic [STEPS-1:0]  toggled;

	assign tempo_c = (tempo_q < dss_pkg::TEMPO_MIN) ? dss_pkg::TEMPO_MIN :
		(tempo_q > dss_pkg::TEMPO_MAX) ? dss_pkg::TEMPO_MAX : tempo_q;
	assign swing_c = (swing_q > dss_pkg::SWING_MAX) ? dss_pkg::SWING_MAX : swing_q;
	assign factor  = parity_q ? (dss_pkg::SWING_SCALE + {2'b00, swing_c, 1'b0})
		: (dss_pkg::SWING_SCALE - {3'b000, swing_c});

	assign div_req.start = div_start;
	assign div_req.num   = NW'(NW'(factor) * NW'(dss_pkg::STEP_MS_NUM));
	assign div_req.den   = DW'(DW'(tempo_c) * DW'(dss_pkg::SWING_SCALE));

	assign slot_eff = SW'(dss_pkg::slot_mod(slot_q, SLOTS));
	assign rd_voice = (state_q == dss_pkg::S_TRIG) ? vcnt_q : voice_q;
	assign key_ok   = 32'(key_q) < STEPS;
	assign toggled  = rd_data ^ (STEPS'(1) << key_q);
	assign fire     = EW'(div_rsp.quo) <= elapsed_q;
	assign accept   = evt_valid && evt_ready;

	dss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dss_pat_mem #(
		.STEPS  (STEPS),
		.VOICES (VOICES),
		.SLOTS  (SLOTS),
		.VW     (VW),
		.SW     (SW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (mem_rd_en),
		.rd_slot  (slot_eff),
		.rd_voice (rd_voice),
		.rd_data  (rd_data),
		.wr_en    (mem_wr_en),
		.wr_slot  (slot_eff),
		.wr_voice (voice_q),
		.wr_data  (toggled)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dss_pkg::S_IDLE: begin
				if (evt_valid) begin
					if (evt.kind == dss_pkg::KIND_TICK && running_q) begin
						state_d = dss_pkg::S_DIV;
					end else begin
						state_d = dss_pkg::S_ROW_RD;
					end
				end
			end
			dss_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_d = fire ? dss_pkg::S_TRIG : dss_pkg::S_ROW_RD;
				end
			end
			dss_pkg::S_TRIG: begin
				if (vcnt_q == VW'(VOICES - 1)) begin
					state_d = dss_pkg::S_ROW_RD;
				end
			end
			dss_pkg::S_ROW_RD:   state_d = dss_pkg::S_ROW_WAIT;
			dss_pkg::S_ROW_WAIT: state_d = dss_pkg::S_DONE;
			dss_pkg::S_DONE: begin
				if (!res_valid_q || res_ready) begin
					state_d = dss_pkg::S_IDLE;
				end
			end
			default: state_d = dss_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		evt_ready = 1'b0;
		div_start = 1'b0;
		mem_rd_en = 1'b0;
		mem_wr_en = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			dss_pkg::S_IDLE: begin
				evt_ready = 1'b1;
				div_start = evt_valid && evt.kind == dss_pkg::KIND_TICK && running_q;
			end
			dss_pkg::S_TRIG:     mem_rd_en = 1'b1;
			dss_pkg::S_ROW_RD:   mem_rd_en = 1'b1;
			dss_pkg::S_ROW_WAIT: mem_wr_en = kind_q == dss_pkg::KIND_TOGGLE_STEP && key_ok;
			dss_pkg::S_DONE:     res_load = !res_valid_q || res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dss_pkg::S_IDLE;
			tempo_q      <= dss_pkg::TEMPO_RST;
			swing_q      <= '0;
			slot_q       <= '0;
			elapsed_q    <= '0;
			playhead_q   <= '0;
			armed_q      <= 1'b0;
			running_q    <= 1'b1;
			parity_q     <= 1'b0;
			voice_q      <= '0;
			res_valid_q  <= 1'b0;
			trig_pend_s1 <= 1'b0;
		end else begin
			state_q      <= state_d;
			trig_pend_s1 <= state_q == dss_pkg::S_TRIG;
			if (cfg_we) begin
				case (cfg_index)
					dss_pkg::CFG_TEMPO: tempo_q <= cfg_data;
					dss_pkg::CFG_SWING: swing_q <= cfg_data[5:0];
					dss_pkg::CFG_SLOT:  slot_q  <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (accept) begin
				case (evt.kind)
					dss_pkg::KIND_TICK: begin
						if (elapsed_q != '1) begin
							elapsed_q <= elapsed_q + EW'(1);
						end
					end
					dss_pkg::KIND_NEXT_VOICE: begin
						voice_q <= (voice_q == VW'(VOICES - 1)) ? '0 : voice_q + VW'(1);
					end
					dss_pkg::KIND_PLAY_STOP: begin
						running_q <= !running_q;
						if (running_q) begin
							armed_q    <= 1'b0;
							playhead_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (state_q == dss_pkg::S_DIV && div_rsp.done && fire) begin
				if (armed_q && playhead_q != PW'(STEPS - 1)) begin
					playhead_q <= playhead_q + PW'(1);
				end else begin
					playhead_q <= '0;
				end
				armed_q   <= 1'b1;
				parity_q  <= !parity_q;
				elapsed_q <= '0;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		trig_v_s1 <= vcnt_q;
		if (accept) begin
			kind_q  <= evt.kind;
			key_q   <= evt.step_key;
			fired_q <= 1'b0;
			trig_q  <= '0;
		end
		if (state_q == dss_pkg::S_DIV && div_rsp.done && fire) begin
			fired_q <= 1'b1;
			vcnt_q  <= '0;
		end
		if (state_q == dss_pkg::S_TRIG) begin
			vcnt_q <= vcnt_q + VW'(1);
		end
		if (trig_pend_s1) begin
			trig_q[trig_v_s1] <= rd_data[playhead_q];
		end
		if (state_q == dss_pkg::S_ROW_WAIT) begin
			row_q <= mem_wr_en ? toggled : rd_data;
		end
		if (res_load) begin
			res_q.fired          <= fired_q;
			res_q.playhead_valid <= armed_q;
			res_q.step_index     <= armed_q ? 4'(playhead_q) : 4'd0;
			res_q.triggers       <= 6'(trig_q);
			res_q.playing        <= running_q;
			res_q.selected_voice <= 3'(voice_q);
			res_q.voice_row      <= 16'(row_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

[src/dss_div.sv]
// Iterative restoring divider producing the step interval, one quotient bit per cycle.
`default_nettype none
module dss_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dss_pkg::div_req_t req,
	output dss_pkg::div_rsp_t      rsp
);

	localparam int NW = dss_pkg::NUM_W;
	localparam int DW = dss_pkg::DEN_W;
	localparam int QW = dss_pkg::QUO_W;
	localparam int CW = dss_pkg::CNT_W;
	localparam int SHW = DW + QW - 1;

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [NW-1:0]   rem_q;
	logic [SHW-1:0]  den_sh_q;
	logic [QW-1:0]   quo_q;
	logic            ge;

	assign ge = SHW'(rem_q) >= den_sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q    <= req.num;
			den_sh_q <= {req.den, {(QW-1){1'b0}}};
			quo_q    <= '0;
			cnt_q    <= CW'(QW - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= NW'(SHW'(rem_q) - den_sh_q);
			end
			quo_q    <= {quo_q[QW-2:0], ge};
			den_sh_q <= den_sh_q >> 1;
			cnt_q    <= cnt_q - CW'(1);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
`default_nettype wire

[src/dss_pat_mem.sv]
// Pattern memory: one row of step bits per slot and voice, default grooves until written.
`default_nettype none
module dss_pat_mem #(
	parameter int STEPS  = dss_pkg::STEPS_DEF,
	parameter int VOICES = dss_pkg::VOICES_DEF,
	parameter int SLOTS  = dss_pkg::SLOTS_DEF,
	parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1,
	parameter int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [SW-1:0]    rd_slot,
	input  wire logic [VW-1:0]    rd_voice,
	output logic      [STEPS-1:0] rd_data,
	input  wire logic             wr_en,
	input  wire logic [SW-1:0]    wr_slot,
	input  wire logic [VW-1:0]    wr_voice,
	input  wire logic [STEPS-1:0] wr_data
);

	localparam int DEPTH = SLOTS * VOICES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [STEPS-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [STEPS-1:0] rd_data_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [STEPS-1:0] dflt_row;

	assign rd_addr  = AW'(AW'(rd_slot) * AW'(VOICES) + AW'(rd_voice));
	assign wr_addr  = AW'(AW'(wr_slot) * AW'(VOICES) + AW'(wr_voice));
	assign dflt_row = STEPS'(dss_pkg::groove_row(4'(rd_slot), 4'(rd_voice)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : dflt_row;
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire
